// File: hdl/ftfc_pkg.sv
package ftfc_pkg;

  localparam int DELTA_W = 31;
  localparam int SCALE_W = 24;
  localparam int MAG_W   = 23;
  localparam int STEPS_W = 7;
  localparam int TIME_W  = 64;
  localparam int GSTEP_W = 39;
  localparam int CFG_W   = 31;
  localparam int CIDX_W  = 3;
  localparam int UPC_W   = 3;

  // 1/60 s in Q7.24, truncated
  localparam logic [DELTA_W-1:0] DEFAULT_STEP = 31'd279620;

  localparam logic [DELTA_W-1:0] RST_FIXED_STEP = 31'd279620;
  localparam logic [7:0]         RST_MAX_STEPS  = 8'd4;
  localparam logic [SCALE_W-1:0] RST_SCALE      = 24'd65536;
  localparam logic [DELTA_W-1:0] RST_MAX_DELTA  = 31'd4194304;

  typedef enum logic [CIDX_W-1:0] {
    REG_FIXED_STEP = 3'd0,
    REG_MAX_STEPS  = 3'd1,
    REG_GAME_SCALE = 3'd2,
    REG_ANIM_SCALE = 3'd3,
    REG_MAX_DELTA  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CLAMP,
    OP_NOP,
    OP_MULG,
    OP_MULA,
    OP_ACCUM,
    OP_DRAIN,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_NO_INPUT,
    COND_PAUSE,
    COND_DRAIN,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic pause;
    logic drain_more;
    logic out_busy;
  } seq_status_t;

  localparam upc_t UPC_WAIT  = 3'd0;
  localparam upc_t UPC_DRAIN = 3'd6;
  localparam upc_t UPC_OUT   = 3'd7;

  // Control store. Falling through the last word wraps back to the wait step.
  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    unique case (upc)
      3'd0:    w = '{op: OP_WAIT,  cond: COND_NO_INPUT, target: UPC_WAIT};
      3'd1:    w = '{op: OP_CLAMP, cond: COND_NEXT,     target: UPC_WAIT};
      3'd2:    w = '{op: OP_NOP,   cond: COND_PAUSE,    target: UPC_OUT};
      3'd3:    w = '{op: OP_MULG,  cond: COND_NEXT,     target: UPC_WAIT};
      3'd4:    w = '{op: OP_MULA,  cond: COND_NEXT,     target: UPC_WAIT};
      3'd5:    w = '{op: OP_ACCUM, cond: COND_NEXT,     target: UPC_WAIT};
      3'd6:    w = '{op: OP_DRAIN, cond: COND_DRAIN,    target: UPC_DRAIN};
      3'd7:    w = '{op: OP_OUT,   cond: COND_OUT_BUSY, target: UPC_OUT};
      default: w = '{op: OP_WAIT,  cond: COND_NO_INPUT, target: UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/ftfc_in_if.sv
interface ftfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] real_delta;
  logic               pause;

  modport source(output valid, real_delta, pause, input ready);
  modport sink(input valid, real_delta, pause, output ready);
endinterface

// File: hdl/ftfc_out_if.sv
interface ftfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_number;
  logic [30:0] real_step;
  logic [38:0] game_step;
  logic [38:0] anim_step;
  logic [63:0] real_total;
  logic [63:0] game_total;
  logic [63:0] anim_total;
  logic [63:0] fixed_total;
  logic [63:0] leftover;
  logic [6:0]  steps_taken;
  logic        clamped;
  logic        paused_now;

  modport source(output valid, frame_number, real_step, game_step, anim_step, real_total,
                 game_total, anim_total, fixed_total, leftover, steps_taken, clamped,
                 paused_now, input ready);
  modport sink(input valid, frame_number, real_step, game_step, anim_step, real_total,
               game_total, anim_total, fixed_total, leftover, steps_taken, clamped,
               paused_now, output ready);
endinterface

// File: hdl/fixed_timestep_frame_clock_top.sv
// Fixed-timestep frame clock. One transfer in per rendered frame (signed Q8.24
// delta plus pause), one transfer out with the clamped delta, scaled game and
// animation deltas, the Q40.24 clocks, the accumulator remainder and the number
// of fixed steps to run. Control is an 8-word microprogram stepping a small
// datapath with one shared 31x23 multiplier. A paused frame jumps from the
// pause-test word to the output word; otherwise the multiply and accumulate
// words follow and the drain word runs n fixed steps, one per cycle, where n
// is at most STEP_LIMIT, before the output word. The wait word follows the
// output word. The next frame is taken once the result sits in the output
// register, so a slow consumer only stalls the block when a second result is
// ready. Settings are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
module fixed_timestep_frame_clock_top #(
  parameter int STEP_LIMIT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ftfc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ftfc_pkg::CFG_W-1:0]    cfg_data,
  ftfc_in_if.sink                       frame_in,
  ftfc_out_if.source                    frame_out
);

  localparam int DW = ftfc_pkg::DELTA_W;
  localparam int MW = ftfc_pkg::MAG_W;
  localparam int SW = ftfc_pkg::STEPS_W;
  localparam int TW = ftfc_pkg::TIME_W;
  localparam int GW = ftfc_pkg::GSTEP_W;
  localparam int PW = DW + MW;

  // ---------------- configuration registers ----------------
  logic [DW-1:0]                 fixed_step;
  logic [7:0]                    max_steps;
  logic [ftfc_pkg::SCALE_W-1:0]  game_scale;
  logic [ftfc_pkg::SCALE_W-1:0]  anim_scale;
  logic [DW-1:0]                 max_frame_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step      <= ftfc_pkg::RST_FIXED_STEP;
      max_steps       <= ftfc_pkg::RST_MAX_STEPS;
      game_scale      <= ftfc_pkg::RST_SCALE;
      anim_scale      <= ftfc_pkg::RST_SCALE;
      max_frame_delta <= ftfc_pkg::RST_MAX_DELTA;
    end else if (cfg_we) begin
      case (cfg_index)
        ftfc_pkg::REG_FIXED_STEP: fixed_step      <= cfg_data;
        ftfc_pkg::REG_MAX_STEPS:  max_steps       <= cfg_data[7:0];
        ftfc_pkg::REG_GAME_SCALE: game_scale      <= cfg_data[ftfc_pkg::SCALE_W-1:0];
        ftfc_pkg::REG_ANIM_SCALE: anim_scale      <= cfg_data[ftfc_pkg::SCALE_W-1:0];
        ftfc_pkg::REG_MAX_DELTA:  max_frame_delta <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- sequencer ----------------
  ftfc_pkg::uword_t      uword;
  ftfc_pkg::seq_status_t status;

  ftfc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  // ---------------- datapath registers ----------------
  logic [31:0]   raw;          // latched input delta
  logic          paused_flag;  // pause of the current frame
  logic [DW-1:0] delta;        // clamped real delta
  logic [DW-1:0] step;         // effective fixed step
  logic [SW-1:0] limit;        // effective per-frame step limit
  logic [MW-1:0] gs;
  logic [MW-1:0] as_mag;
  logic          flag;
  logic [GW-1:0] gstep;
  logic [GW-1:0] astep;
  logic [SW-1:0] steps;

  logic [TW-1:0] frame_count;
  logic [TW-1:0] real_time;
  logic [TW-1:0] game_time;
  logic [TW-1:0] anim_time;
  logic [TW-1:0] fixed_time;
  logic [TW-1:0] accumulator;

  // ---------------- clamp logic (used in the clamp word) ----------------
  logic [DW-1:0] d_pos;
  logic          d_neg;
  logic          d_over;
  logic          step_zero;
  logic          limit_over;
  logic          gs_neg;
  logic          as_neg;

  always_comb begin
    d_neg      = raw[31];
    d_pos      = d_neg ? '0 : raw[DW-1:0];
    d_over     = d_pos > max_frame_delta;
    step_zero  = fixed_step == '0;
    limit_over = max_steps > 8'(STEP_LIMIT);
    gs_neg     = game_scale[ftfc_pkg::SCALE_W-1];
    as_neg     = anim_scale[ftfc_pkg::SCALE_W-1];
  end

  // Shared multiplier: game scale in the first multiply word, animation next.
  logic [MW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  assign mul_b = (uword.op == ftfc_pkg::OP_MULA) ? as_mag : gs;
  assign mul_p = PW'(delta) * PW'(mul_b);

  // Drain test: one 64-bit compare per drain cycle.
  logic drain_more;
  assign drain_more = (steps < limit) && (accumulator >= TW'(step));

  // ---------------- handshakes ----------------
  logic out_busy;
  assign out_busy       = frame_out.valid && !frame_out.ready;
  assign frame_in.ready = (uword.op == ftfc_pkg::OP_WAIT);

  assign status = '{in_valid:   frame_in.valid,
                    pause:      paused_flag,
                    drain_more: drain_more,
                    out_busy:   out_busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= '0;
      real_time       <= '0;
      game_time       <= '0;
      anim_time       <= '0;
      fixed_time      <= '0;
      accumulator     <= '0;
      paused_flag     <= 1'b0;
      frame_out.valid <= 1'b0;
    end else begin
      // the output word reloads valid itself
      if (frame_out.valid && frame_out.ready && uword.op != ftfc_pkg::OP_OUT) begin
        frame_out.valid <= 1'b0;
      end
      case (uword.op)
        ftfc_pkg::OP_WAIT: begin
          if (frame_in.valid) begin
            raw         <= frame_in.real_delta;
            paused_flag <= frame_in.pause;
          end
        end
        ftfc_pkg::OP_CLAMP: begin
          delta  <= d_over ? max_frame_delta : d_pos;
          step   <= step_zero ? ftfc_pkg::DEFAULT_STEP : fixed_step;
          limit  <= limit_over ? SW'(STEP_LIMIT) : SW'(max_steps);
          gs     <= gs_neg ? '0 : game_scale[MW-1:0];
          as_mag <= as_neg ? '0 : anim_scale[MW-1:0];
          flag   <= d_neg | d_over | step_zero | limit_over | gs_neg | as_neg;
          gstep  <= '0;
          astep  <= '0;
          steps  <= '0;
          if (frame_count != '1) begin
            frame_count <= frame_count + 1'b1;
          end
          real_time <= real_time + TW'(d_over ? max_frame_delta : d_pos);
        end
        ftfc_pkg::OP_MULG: begin
          gstep <= GW'(mul_p[PW-1:16]);
        end
        ftfc_pkg::OP_MULA: begin
          astep     <= GW'(mul_p[PW-1:16]);
          game_time <= game_time + TW'(gstep);
        end
        ftfc_pkg::OP_ACCUM: begin
          anim_time   <= anim_time + TW'(astep);
          accumulator <= accumulator + TW'(delta);
        end
        ftfc_pkg::OP_DRAIN: begin
          if (drain_more) begin
            accumulator <= accumulator - TW'(step);
            fixed_time  <= fixed_time + TW'(step);
            steps       <= steps + 1'b1;
          end
        end
        ftfc_pkg::OP_OUT: begin
          if (!out_busy) begin
            frame_out.valid        <= 1'b1;
            frame_out.frame_number <= frame_count;
            frame_out.real_step    <= delta;
            frame_out.game_step    <= gstep;
            frame_out.anim_step    <= astep;
            frame_out.real_total   <= real_time;
            frame_out.game_total   <= game_time;
            frame_out.anim_total   <= anim_time;
            frame_out.fixed_total  <= fixed_time;
            frame_out.leftover     <= accumulator;
            frame_out.steps_taken  <= steps;
            frame_out.clamped      <= flag;
            frame_out.paused_now   <= paused_flag;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/ftfc_seq.sv
module ftfc_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  ftfc_pkg::seq_status_t status,
  output ftfc_pkg::uword_t     uword
);

  ftfc_pkg::upc_t upc;
  ftfc_pkg::upc_t upc_next;
  logic           take;

  assign uword = ftfc_pkg::ucode(upc);

  always_comb begin
    case (uword.cond)
      ftfc_pkg::COND_NO_INPUT: take = !status.in_valid;
      ftfc_pkg::COND_PAUSE:    take = status.pause;
      ftfc_pkg::COND_DRAIN:    take = status.drain_more;
      ftfc_pkg::COND_OUT_BUSY: take = status.out_busy;
      default:                 take = 1'b0;
    endcase
    upc_next = take ? uword.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ftfc_pkg::UPC_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
